// ----- rtl/core/ip_flow_selector_parser_assert.svh -----
// Assertion macros used by the RTL. Each use expects clk and rst_n in scope.
`ifndef IP_FLOW_SELECTOR_PARSER_ASSERT_SVH
`define IP_FLOW_SELECTOR_PARSER_ASSERT_SVH

`define IFSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define IFSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/ifsp_pkg.sv -----
`timescale 1ns / 1ps

package ifsp_pkg;

    localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

    localparam logic [7:0] VER_MASK = 8'hF0;
    localparam logic [7:0] VER_V4   = 8'h40;
    localparam logic [7:0] VER_V6   = 8'h60;
    localparam logic [3:0] MIN_IHL  = 4'd5;
    localparam logic [16:0] V6_HDR_LEN = 17'd40;

    localparam logic [63:0] MAPPED_LO = 64'h0000_FFFF_0000_0000;

    localparam logic [7:0] PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0] PROTO_ICMP     = 8'd1;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_ICMPV6   = 8'd58;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;
    localparam logic [7:0] PROTO_SCTP     = 8'd132;
    localparam logic [7:0] PROTO_MOBILITY = 8'd135;
    localparam logic [7:0] PROTO_UDPLITE  = 8'd136;

    localparam logic [15:0] V4_PROTO_POS   = 16'd9;
    localparam logic [15:0] V4_SRC_FIRST   = 16'd12;
    localparam logic [15:0] V4_SRC_LAST    = 16'd15;
    localparam logic [15:0] V4_DST_FIRST   = 16'd16;
    localparam logic [15:0] V4_DST_LAST    = 16'd19;
    localparam logic [15:0] V6_PROTO_POS   = 16'd6;
    localparam logic [15:0] V6_SRC_HI_FIRST = 16'd8;
    localparam logic [15:0] V6_SRC_HI_LAST  = 16'd15;
    localparam logic [15:0] V6_SRC_LO_LAST  = 16'd23;
    localparam logic [15:0] V6_DST_HI_LAST  = 16'd31;
    localparam logic [15:0] V6_DST_LO_LAST  = 16'd39;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2,
        KIND_BAD  = 2'd3
    } ver_kind_t;

    typedef enum logic [1:0] {
        PORTS_NONE = 2'd0,
        PORTS_TYPE = 2'd1,
        PORTS_PAIR = 2'd2
    } port_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       inbound;
    } pkt_byte_t;

    typedef struct packed {
        logic        discard;
        logic        inbound_flag;
        logic [63:0] local_addr_hi;
        logic [63:0] local_addr_lo;
        logic [63:0] remote_addr_hi;
        logic [63:0] remote_addr_lo;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [7:0]  transport_proto;
        logic [1:0]  port_kind;
    } selector_t;

endpackage

// ----- rtl/core/ip_flow_selector_parser.sv -----
`timescale 1ns / 1ps
// Flow selector parser for IPv4 and IPv6 packets.
// The byte channel (byte_valid, byte_stall, byte_item) carries one packet byte
// per item, starting at the network header, with a last-byte mark and the
// direction bit, which is sampled on the last byte.
// The selector channel (sel_valid, sel_stall, sel_item) carries one item per
// packet: addresses arranged as local and remote, ports or message type, the
// protocol where the extension header walk stopped, and a discard flag.
// Each byte is processed in the cycle it is accepted; sel_valid is high in the
// cycle after the last byte is accepted, carrying this or an earlier selector.
// One byte is taken every cycle while byte_stall is low. A single selector
// waiting on a stalled receiver does not hold up the byte channel; a second one
// is kept in a skid register, and byte_stall is raised only while it is full.
// Reset sets the parse state to its reset value and empties both result registers.
// After each last byte the parse state returns to that value for the next packet.
// Bytes beyond the maximum packet length are ignored apart from the mark.
module ip_flow_selector_parser
    import ifsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  pkt_byte_t byte_item,
    output logic      sel_valid,
    input  logic      sel_stall,
    output selector_t sel_item
);

`include "ip_flow_selector_parser_assert.svh"

    logic [15:0] pos_reg, pos_next;
    logic [16:0] hstart_reg, hstart_next;
    logic [7:0]  proto_reg, proto_next;
    ver_kind_t   kind_reg, kind_next;
    logic        done_reg, done_next;
    logic [31:0] hbytes_reg, hbytes_next;
    logic [63:0] loc_hi_reg, loc_hi_next;
    logic [63:0] loc_lo_reg, loc_lo_next;
    logic [63:0] rem_hi_reg, rem_hi_next;
    logic [63:0] rem_lo_reg, rem_lo_next;
    logic [15:0] port0_reg, port0_next;
    logic [15:0] port1_reg, port1_next;
    port_kind_t  pkind_reg, pkind_next;

    logic        out_valid_reg;
    selector_t   out_data_reg;
    logic        skid_valid_reg;
    selector_t   skid_data_reg;

    logic        byte_take;
    logic        produce;
    logic        out_take;
    logic [7:0]  d;
    logic [7:0]  b0, b1, b2, b3;
    selector_t   result;

    function automatic logic [63:0] put_byte(logic [63:0] w, logic [2:0] slot,
                                             logic [7:0] v);
        logic [5:0] sh;
        sh = {slot, 3'b000};
        return (w & ~(64'hFF << sh)) | (64'(v) << sh);
    endfunction

    assign byte_stall = skid_valid_reg;
    assign byte_take  = byte_valid && !byte_stall;
    assign produce    = byte_take && byte_item.last_byte;
    assign out_take   = out_valid_reg && !sel_stall;
    assign d  = byte_item.data_byte;
    assign b0 = hbytes_reg[31:24];
    assign b1 = hbytes_reg[23:16];
    assign b2 = hbytes_reg[15:8];
    assign b3 = hbytes_reg[7:0];

    always_comb
    begin
        pos_next    = pos_reg;
        hstart_next = hstart_reg;
        proto_next  = proto_reg;
        kind_next   = kind_reg;
        done_next   = done_reg;
        hbytes_next = hbytes_reg;
        loc_hi_next = loc_hi_reg;
        loc_lo_next = loc_lo_reg;
        rem_hi_next = rem_hi_reg;
        rem_lo_next = rem_lo_reg;
        port0_next  = port0_reg;
        port1_next  = port1_reg;
        pkind_next  = pkind_reg;

        if (pos_reg < MAX_PACKET_BYTES)
        begin
            if (pos_reg == 16'd0)
            begin
                priority if ((d & VER_MASK) == VER_V4)
                begin
                    if (d[3:0] < MIN_IHL)
                    begin
                        kind_next = KIND_BAD;
                    end
                    else
                    begin
                        kind_next   = KIND_V4;
                        hstart_next = {11'd0, d[3:0], 2'b00};
                    end
                end
                else if ((d & VER_MASK) == VER_V6)
                begin
                    kind_next   = KIND_V6;
                    hstart_next = V6_HDR_LEN;
                end
                else
                begin
                    kind_next = KIND_BAD;
                end
            end
            else if (kind_reg == KIND_V4)
            begin
                priority if (pos_reg == V4_PROTO_POS)
                begin
                    proto_next = d;
                end
                else if (pos_reg >= V4_SRC_FIRST && pos_reg <= V4_SRC_LAST)
                begin
                    loc_lo_next = put_byte(loc_lo_reg, ~pos_reg[2:0], d);
                end
                else if (pos_reg >= V4_DST_FIRST && pos_reg <= V4_DST_LAST)
                begin
                    rem_lo_next = put_byte(rem_lo_reg, 3'(3'd3 - pos_reg[2:0]), d);
                end
                else
                begin
                    proto_next = proto_reg;
                end
            end
            else if (kind_reg == KIND_V6)
            begin
                priority if (pos_reg == V6_PROTO_POS)
                begin
                    proto_next = d;
                end
                else if (pos_reg >= V6_SRC_HI_FIRST && pos_reg <= V6_SRC_HI_LAST)
                begin
                    loc_hi_next = put_byte(loc_hi_reg, ~pos_reg[2:0], d);
                end
                else if (pos_reg > V6_SRC_HI_LAST && pos_reg <= V6_SRC_LO_LAST)
                begin
                    loc_lo_next = put_byte(loc_lo_reg, ~pos_reg[2:0], d);
                end
                else if (pos_reg > V6_SRC_LO_LAST && pos_reg <= V6_DST_HI_LAST)
                begin
                    rem_hi_next = put_byte(rem_hi_reg, ~pos_reg[2:0], d);
                end
                else if (pos_reg > V6_DST_HI_LAST && pos_reg <= V6_DST_LO_LAST)
                begin
                    rem_lo_next = put_byte(rem_lo_reg, ~pos_reg[2:0], d);
                end
                else
                begin
                    proto_next = proto_reg;
                end
            end

            if ((kind_reg == KIND_V4 || kind_reg == KIND_V6) && !done_reg &&
                pos_reg != 16'd0 && {2'b00, pos_reg} == 18'(hstart_reg) + 18'd4)
            begin
                done_next = 1'b1;
                unique case (proto_next)
                    PROTO_HOPOPT, PROTO_ROUTING, PROTO_DSTOPTS:
                    begin
                        proto_next  = b0;
                        hstart_next = hstart_reg + {6'd0, b1, 3'b000} + 17'd8;
                        done_next   = 1'b0;
                    end
                    PROTO_ICMP, PROTO_ICMPV6:
                    begin
                        port0_next = {b0, b1};
                        pkind_next = PORTS_TYPE;
                    end
                    PROTO_TCP, PROTO_UDP, PROTO_SCTP, PROTO_UDPLITE:
                    begin
                        port0_next = {b0, b1};
                        port1_next = {b2, b3};
                        pkind_next = PORTS_PAIR;
                    end
                    PROTO_MOBILITY:
                    begin
                        port0_next = {b2, 8'd0};
                        pkind_next = PORTS_TYPE;
                    end
                    default:
                    begin
                        pkind_next = pkind_reg;
                    end
                endcase
            end

            hbytes_next = {hbytes_reg[23:0], d};
            pos_next    = pos_reg + 16'd1;
        end
    end

    always_comb
    begin
        result = '0;
        if (kind_next == KIND_BAD)
        begin
            result.discard = 1'b1;
        end
        else
        begin
            result.inbound_flag    = byte_item.inbound;
            result.transport_proto = proto_next;
            result.port_kind       = pkind_next;
            if (byte_item.inbound)
            begin
                result.local_addr_hi  = rem_hi_next;
                result.local_addr_lo  = rem_lo_next;
                result.remote_addr_hi = loc_hi_next;
                result.remote_addr_lo = loc_lo_next;
            end
            else
            begin
                result.local_addr_hi  = loc_hi_next;
                result.local_addr_lo  = loc_lo_next;
                result.remote_addr_hi = rem_hi_next;
                result.remote_addr_lo = rem_lo_next;
            end
            unique case (pkind_next)
                PORTS_PAIR:
                begin
                    result.local_port  = byte_item.inbound ? port1_next : port0_next;
                    result.remote_port = byte_item.inbound ? port0_next : port1_next;
                end
                PORTS_TYPE:
                begin
                    result.local_port = port0_next;
                end
                default:
                begin
                    result.local_port = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hstart_reg <= '0;
            proto_reg  <= '0;
            kind_reg   <= KIND_NONE;
            done_reg   <= 1'b0;
            hbytes_reg <= '0;
            loc_hi_reg <= '0;
            loc_lo_reg <= MAPPED_LO;
            rem_hi_reg <= '0;
            rem_lo_reg <= MAPPED_LO;
            port0_reg  <= '0;
            port1_reg  <= '0;
            pkind_reg  <= PORTS_NONE;
        end
        else if (produce)
        begin
            pos_reg    <= '0;
            hstart_reg <= '0;
            proto_reg  <= '0;
            kind_reg   <= KIND_NONE;
            done_reg   <= 1'b0;
            hbytes_reg <= '0;
            loc_hi_reg <= '0;
            loc_lo_reg <= MAPPED_LO;
            rem_hi_reg <= '0;
            rem_lo_reg <= MAPPED_LO;
            port0_reg  <= '0;
            port1_reg  <= '0;
            pkind_reg  <= PORTS_NONE;
        end
        else if (byte_take)
        begin
            pos_reg    <= pos_next;
            hstart_reg <= hstart_next;
            proto_reg  <= proto_next;
            kind_reg   <= kind_next;
            done_reg   <= done_next;
            hbytes_reg <= hbytes_next;
            loc_hi_reg <= loc_hi_next;
            loc_lo_reg <= loc_lo_next;
            rem_hi_reg <= rem_hi_next;
            rem_lo_reg <= rem_lo_next;
            port0_reg  <= port0_next;
            port1_reg  <= port1_next;
            pkind_reg  <= pkind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= produce;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (produce && (out_take || !out_valid_reg))
        begin
            out_data_reg <= result;
        end
        if (produce && out_valid_reg && !out_take)
        begin
            skid_data_reg <= result;
        end
    end

    assign sel_valid = out_valid_reg;
    assign sel_item  = out_data_reg;

    `IFSP_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `IFSP_ASSERT_NEXT(a_last_gives_sel, produce, sel_valid)
    `IFSP_ASSERT_NEXT(a_last_restarts, produce, pos_reg == 16'd0 && kind_reg == KIND_NONE)
    `IFSP_ASSERT_SAME(a_discard_clean, sel_valid && sel_item.discard,
        sel_item.port_kind == PORTS_NONE && sel_item.transport_proto == 8'd0 &&
        sel_item.local_port == 16'd0 && !sel_item.inbound_flag)

endmodule
